// ===== sv/dlrr_pkg.sv =====
// shared constants and types for the dual generator range random block
package dlrr_pkg;

   localparam int unsigned DATA_WIDTH = 32;
   localparam int unsigned HALF_WIDTH = DATA_WIDTH / 2;
   localparam int unsigned STEP_COUNT_WIDTH = $clog2(DATA_WIDTH);

   localparam logic [DATA_WIDTH-1:0] LCG_FACTOR = 32'd1103515821;
   localparam logic [DATA_WIDTH-1:0] LCG_ADDEND = 32'd12345;
   localparam logic [DATA_WIDTH-1:0] LOW_SOURCE_RESET = 32'h0000_0000;
   localparam logic [DATA_WIDTH-1:0] HIGH_SOURCE_RESET = 32'h0013_CC25;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DRAW,
      ST_DIVIDE,
      ST_FINISH
   } dlrr_state_type;

endpackage

// ===== sv/dlrr_rem.sv =====
// bit-serial restoring remainder unit, one dividend bit per cycle
module dlrr_rem (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [dlrr_pkg::DATA_WIDTH-1:0]   dividend,
   input  logic [dlrr_pkg::DATA_WIDTH-1:0]   divisor,
   output logic                              done,
   output logic [dlrr_pkg::DATA_WIDTH-1:0]   remainder
);
   import dlrr_pkg::*;

   logic                        run_ff, run_in;
   logic                        done_ff, done_in;
   logic [STEP_COUNT_WIDTH-1:0] count_ff, count_in;
   logic [DATA_WIDTH-1:0]       shift_ff, shift_in;
   logic [DATA_WIDTH-1:0]       rem_ff, rem_in;
   logic [DATA_WIDTH-1:0]       div_ff, div_in;
   logic [DATA_WIDTH:0]         trial;
   logic [DATA_WIDTH:0]         diff;

   assign trial = {rem_ff, shift_ff[DATA_WIDTH-1]};
   assign diff  = trial - {1'b0, div_ff};

   always_comb begin
      run_in   = run_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      div_in   = div_ff;
      if (start) begin
         run_in   = 1'b1;
         count_in = '0;
         shift_in = dividend;
         rem_in   = '0;
         div_in   = divisor;
      end else if (run_ff) begin
         shift_in = {shift_ff[DATA_WIDTH-2:0], 1'b0};
         rem_in   = diff[DATA_WIDTH] ? trial[DATA_WIDTH-1:0] : diff[DATA_WIDTH-1:0];
         count_in = count_ff + 1'b1;
         if (count_ff == STEP_COUNT_WIDTH'(DATA_WIDTH - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      count_ff <= count_in;
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      div_ff   <= div_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

// ===== sv/dual_lcg_range_random_core.sv =====
// top level of the dual generator range random block
//
// Request channel (req_valid/req_ready) carries two signed 32-bit bounds in
// either order; the response channel (rsp_valid/rsp_ready) returns one signed
// 32-bit value per request transaction.
// Equal bounds: the accepted request goes straight to the finish state, which
// loads the output register once it is free; the generators keep their state.
// Unequal bounds: the draw state advances both generators and loads a bit-serial
// remainder unit, which works through the dividend bit by bit; the divide state
// adds the lower bound plus one to the remainder and the finish state loads the
// output register. No new request is taken until the core is back in idle, so
// the remainder unit sets the throughput.
// A finished result sits in the output register; the next request can be
// accepted while it waits. When the receiver stalls and a second result is
// ready, the core holds it and takes no new request until the output
// register drains.
// Synchronous reset returns the generators to their seed values, clears the
// output valid flag and leaves the core ready for a request.
module dual_lcg_range_random_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic signed [dlrr_pkg::DATA_WIDTH-1:0] req_bound_first,
   input  logic signed [dlrr_pkg::DATA_WIDTH-1:0] req_bound_second,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [dlrr_pkg::DATA_WIDTH-1:0] rsp_random_value
);
   import dlrr_pkg::*;

   dlrr_state_type          state_ff, state_in;
   logic [DATA_WIDTH-1:0]   gen_lo_ff, gen_lo_in;
   logic [DATA_WIDTH-1:0]   gen_hi_ff, gen_hi_in;
   logic [DATA_WIDTH-1:0]   low_ff, low_in;
   logic [DATA_WIDTH-1:0]   span_ff, span_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [DATA_WIDTH-1:0]   rsp_value_ff, rsp_value_in;
   logic [DATA_WIDTH-1:0]   gen_lo_next;
   logic [DATA_WIDTH-1:0]   gen_hi_next;
   logic [DATA_WIDTH-1:0]   word;
   logic [DATA_WIDTH-1:0]   remainder;
   logic                    accept;
   logic                    out_free;
   logic                    div_start;
   logic                    div_done;

   assign gen_lo_next = DATA_WIDTH'(gen_lo_ff * LCG_FACTOR) + LCG_ADDEND;
   assign gen_hi_next = DATA_WIDTH'(gen_hi_ff * LCG_FACTOR) + LCG_ADDEND;
   assign word        = {gen_hi_next[HALF_WIDTH-1:0], gen_lo_next[DATA_WIDTH-1:HALF_WIDTH]};

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   dlrr_rem u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (word),
      .divisor   (span_ff),
      .done      (div_done),
      .remainder (remainder)
   );

   always_comb begin
      state_in     = state_ff;
      gen_lo_in    = gen_lo_ff;
      gen_hi_in    = gen_hi_ff;
      low_in       = low_ff;
      span_in      = span_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_value_in = rsp_value_ff;
      div_start    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_bound_first > req_bound_second) begin
                  low_in  = req_bound_second;
                  span_in = req_bound_first - req_bound_second;
               end else begin
                  low_in  = req_bound_first;
                  span_in = req_bound_second - req_bound_first;
               end
               state_in = (req_bound_first == req_bound_second) ? ST_FINISH : ST_DRAW;
            end
         end
         ST_DRAW: begin
            gen_lo_in = gen_lo_next;
            gen_hi_in = gen_hi_next;
            div_start = 1'b1;
            state_in  = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (div_done) begin
               state_in = ST_FINISH;
               low_in   = low_ff + remainder + 1'b1;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = low_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         gen_lo_ff    <= LOW_SOURCE_RESET;
         gen_hi_ff    <= HIGH_SOURCE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gen_lo_ff    <= gen_lo_in;
         gen_hi_ff    <= gen_hi_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      low_ff       <= low_in;
      span_ff      <= span_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_random_value = rsp_value_ff;

endmodule

// ===== tb/sv/dlrr_checker.sv =====
// checker for the dual generator range random core: predicts each draw and compares responses
`timescale 1ns / 1ps
module dlrr_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   input  logic                                   req_ready,
   input  logic signed [dlrr_pkg::DATA_WIDTH-1:0] req_bound_first,
   input  logic signed [dlrr_pkg::DATA_WIDTH-1:0] req_bound_second,
   input  logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   input  logic signed [dlrr_pkg::DATA_WIDTH-1:0] rsp_random_value,
   output int                                     failure_count,
   output int                                     pending_count
);
   import dlrr_pkg::*;

   logic [DATA_WIDTH-1:0] low_source;
   logic [DATA_WIDTH-1:0] high_source;
   logic signed [DATA_WIDTH-1:0] expected_values[$];

   task automatic predict_draw(
      input  logic signed [DATA_WIDTH-1:0] first,
      input  logic signed [DATA_WIDTH-1:0] second,
      output logic signed [DATA_WIDTH-1:0] value
   );
      logic signed [DATA_WIDTH-1:0] lower;
      logic signed [DATA_WIDTH-1:0] upper;
      logic [DATA_WIDTH-1:0] word;
      logic [DATA_WIDTH-1:0] span;
      logic [DATA_WIDTH-1:0] offset;
      if (first == second) begin
         value = first;
      end else begin
         if (first > second) begin
            lower = second;
            upper = first;
         end else begin
            lower = first;
            upper = second;
         end
         low_source = low_source * LCG_FACTOR + LCG_ADDEND;
         high_source = high_source * LCG_FACTOR + LCG_ADDEND;
         word = {high_source[HALF_WIDTH-1:0], low_source[DATA_WIDTH-1:HALF_WIDTH]};
         span = upper - lower;
         offset = (span != '0) ? word % span : word;
         value = lower + offset + 1;
      end
   endtask

   always @(posedge clock) begin : monitor
      logic signed [DATA_WIDTH-1:0] predicted;
      logic signed [DATA_WIDTH-1:0] oldest;
      if (reset) begin
         low_source = LOW_SOURCE_RESET;
         high_source = HIGH_SOURCE_RESET;
         expected_values.delete();
         failure_count = 0;
      end else begin
         // response first: it can never belong to a request taken at the same edge
         if (rsp_valid && rsp_ready) begin
            if (expected_values.size() == 0) begin
               $error("random_value: response transaction with nothing expected, actual %0d",
                      rsp_random_value);
               failure_count++;
            end else begin
               oldest = expected_values.pop_front();
               if (rsp_random_value !== oldest) begin
                  $error("random_value mismatch: expected %0d (%h), actual %0d (%h)",
                         oldest, oldest, rsp_random_value, rsp_random_value);
                  failure_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            predict_draw(req_bound_first, req_bound_second, predicted);
            expected_values.push_back(predicted);
         end
      end
      pending_count = expected_values.size();
   end

endmodule

// ===== tb/sv/testbench.sv =====
// top of the testbench: clock, reset, request stimulus, response stalls and verdict
`timescale 1ns / 1ps
module testbench;
   import dlrr_pkg::*;

   typedef logic signed [DATA_WIDTH-1:0] bound_type;

   localparam bound_type MAX_BOUND = 32'sh7FFF_FFFF;
   localparam bound_type MIN_BOUND = 32'sh8000_0000;
   localparam int PHASE_ITEMS = 283;
   localparam int STALL_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 50;

   logic      clock;
   logic      reset;
   logic      req_valid;
   logic      req_ready;
   bound_type req_bound_first;
   bound_type req_bound_second;
   logic      rsp_valid;
   logic      rsp_ready;
   bound_type rsp_random_value;
   int        failure_count;
   int        pending_count;

   int idle_pct = 0;
   int stall_pct = 0;
   int sent_count = 0;
   int equal_count = 0;
   int stalled_cycles = 0;

   dual_lcg_range_random_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_bound_first  (req_bound_first),
      .req_bound_second (req_bound_second),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_random_value (rsp_random_value)
   );

   dlrr_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_bound_first  (req_bound_first),
      .req_bound_second (req_bound_second),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_random_value (rsp_random_value),
      .failure_count    (failure_count),
      .pending_count    (pending_count)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stalled_cycles <= 0;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
      end
      if (stalled_cycles >= STALL_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic send_request(input bound_type first, input bound_type second);
      int gap;
      if ($urandom_range(99) < idle_pct) begin
         gap = $urandom_range(1, 140);
         repeat (gap) begin
            @(negedge clock);
            req_valid <= 1'b0;
         end
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_bound_first <= first;
      req_bound_second <= second;
      do @(posedge clock); while (!req_ready);
      sent_count++;
      if (first == second) equal_count++;
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
   endtask

   function automatic bound_type extreme_value(input int unsigned pick);
      unique case (pick % 4)
         0: return MIN_BOUND;
         1: return MAX_BOUND;
         2: return '0;
         default: return '1;
      endcase
   endfunction

   task automatic send_random_request();
      bound_type first;
      bound_type second;
      int unsigned kind;
      kind = $urandom_range(99);
      first = $urandom;
      if (kind < 12) begin
         second = first;
      end else if (kind < 40) begin
         second = first + $urandom_range(0, 64) - 32;
      end else if (kind < 50) begin
         first = extreme_value($urandom);
         second = $urandom;
      end else if (kind < 55) begin
         first = extreme_value($urandom);
         second = extreme_value($urandom);
      end else begin
         second = $urandom;
      end
      if ($urandom_range(1)) send_request(first, second);
      else send_request(second, first);
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_bound_first = '0;
      req_bound_second = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: equal bounds, order swap, full and tiny spans
      send_request('0, '0);
      send_request(MAX_BOUND, MAX_BOUND);
      send_request(MIN_BOUND, MIN_BOUND);
      send_request(MIN_BOUND, MAX_BOUND);
      send_request(MAX_BOUND, MIN_BOUND);
      send_request(32'sd0, 32'sd1);
      send_request(32'sd1, 32'sd0);
      send_request(-32'sd1, 32'sd0);
      send_request(32'sd5, -32'sd5);
      send_request(MIN_BOUND, MIN_BOUND + 1);
      send_request(MAX_BOUND - 1, MAX_BOUND);
      send_request(-32'sd1, 32'sd1);
      send_request(MIN_BOUND, 32'sd0);
      send_request(32'sd0, MAX_BOUND);
      send_request(32'sd123, 32'sd123);
      send_request(-32'sd2, -32'sd1);
      send_request(MAX_BOUND, 32'sd0);
      send_request(32'sd1000, -32'sd1000);
      send_request(-32'sd1, -32'sd1);
      send_request(MIN_BOUND, -32'sd1);
      send_request(32'sh5555_5555, 32'shAAAA_AAAA);
      wait_for_results();

      for (int phase = 0; phase < 4; phase++) begin
         unique case (phase)
            0: begin idle_pct = 0; stall_pct = 0; end
            1: begin idle_pct = 50; stall_pct = 0; end
            2: begin idle_pct = 0; stall_pct = 50; end
            default: begin idle_pct = 38; stall_pct = 38; end
         endcase
         for (int item = 0; item < PHASE_ITEMS; item++) begin
            if (item == PHASE_ITEMS / 2) wait_for_results();
            send_random_request();
         end
      end

      wait_for_results();
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("covered %0d requests, %0d with equal bounds, including both full-range orders",
               sent_count, equal_count);
      $display("under no idling, sender gaps, receiver stalls and both combined");
      if (failure_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
